// ===== src/gsc_pkg.sv =====
// Shared constants and types for the gamepad sample conditioner.
// Used by gsc_div, gsc_stick and the top level; depends on nothing.
`default_nettype none
package gsc_pkg;

	// Serial divider sizes: 32-bit dividend, 18-bit divisor, one quotient bit a cycle.
	localparam int DIV_W = 32;
	localparam int DEN_W = 18;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Stick arithmetic.
	localparam int AXIS_W = 16;
	localparam int MAG_W = 17;
	localparam int DZ_W = 15;
	localparam int OUT_W = 17;
	localparam int ROOT_W = 16;
	localparam int ROOT_CNT_W = $clog2(ROOT_W);
	localparam logic [DZ_W-1:0] STICK_FULL = 15'd32767;

	// Trigger arithmetic.
	localparam int TRIG_W = 8;
	localparam int TRIG_OUT_W = 16;
	localparam logic [TRIG_W-1:0] TRIG_FULL = 8'd255;

	// Handshake between the top level and a stick lane.
	typedef struct packed {
		logic start;
		logic done;
	} lane_ctl_t;

endpackage
`default_nettype wire

// ===== src/gsc_div.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
// Depends on gsc_pkg for its widths.
`default_nettype none
module gsc_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [gsc_pkg::DIV_W-1:0]   dividend,
	input  wire logic [gsc_pkg::DEN_W-1:0]   divisor,
	output logic                             done,
	output logic [gsc_pkg::DIV_W-1:0]        quotient
);

	logic [gsc_pkg::DIV_W-1:0]     quo_q;
	logic [gsc_pkg::DEN_W-1:0]     rem_q;
	logic [gsc_pkg::DEN_W-1:0]     den_q;
	logic [gsc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [gsc_pkg::DEN_W:0]       trial;
	logic                          ge;
	logic [gsc_pkg::DEN_W:0]       diff;

	// One restoring step: bring down the next dividend bit and try the divisor.
	always_comb begin
		trial = {rem_q, quo_q[gsc_pkg::DIV_W-1]};
		ge = trial >= {1'b0, den_q};
		diff = trial - {1'b0, den_q};
	end

	// Control: a run takes one restoring step per dividend bit, then done pulses.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == gsc_pkg::DIV_CNT_W'(gsc_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend register fills with quotient bits from the right.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[gsc_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? diff[gsc_pkg::DEN_W-1:0] : trial[gsc_pkg::DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== src/gsc_stick.sv =====
// One stick lane: magnitude by serial square root, radial deadzone and rescale.
// Depends on gsc_pkg and instantiates gsc_div for its three divisions.
`default_nettype none
module gsc_stick (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic signed [gsc_pkg::AXIS_W-1:0] x,
	input  wire logic signed [gsc_pkg::AXIS_W-1:0] y,
	input  wire logic [gsc_pkg::DZ_W-1:0]          deadzone,
	output logic                                  done,
	output logic signed [gsc_pkg::OUT_W-1:0]      out_x,
	output logic signed [gsc_pkg::OUT_W-1:0]      out_y
);

	typedef enum logic [12:0] {
		L_IDLE = 13'b0000000000001,
		L_SQX  = 13'b0000000000010,
		L_SQY  = 13'b0000000000100,
		L_ROOT = 13'b0000000001000,
		L_NLD  = 13'b0000000010000,
		L_NDIV = 13'b0000000100000,
		L_XMUL = 13'b0000001000000,
		L_XLD  = 13'b0000010000000,
		L_XDIV = 13'b0000100000000,
		L_YMUL = 13'b0001000000000,
		L_YLD  = 13'b0010000000000,
		L_YDIV = 13'b0100000000000,
		L_DONE = 13'b1000000000000
	} lane_state_t;

	lane_state_t                       state_q;
	logic [gsc_pkg::MAG_W-1:0]         ax_q;
	logic [gsc_pkg::MAG_W-1:0]         ay_q;
	logic                              sx_q;
	logic                              sy_q;
	logic [gsc_pkg::DZ_W-1:0]          dz_q;
	logic [gsc_pkg::DIV_W-1:0]         sum_q;
	logic [gsc_pkg::DIV_W-1:0]         rad_q;
	logic [gsc_pkg::ROOT_W-1:0]        root_q;
	logic [gsc_pkg::DEN_W-1:0]         srem_q;
	logic [gsc_pkg::ROOT_CNT_W-1:0]    rcnt_q;
	logic [gsc_pkg::MAG_W-1:0]         n_q;
	logic [gsc_pkg::DIV_W-1:0]         prod_q;
	logic signed [gsc_pkg::OUT_W-1:0]  ox_q;
	logic signed [gsc_pkg::OUT_W-1:0]  oy_q;

	logic [gsc_pkg::MAG_W-1:0]         mul_a;
	logic [gsc_pkg::MAG_W-1:0]         mul_b;
	logic [2*gsc_pkg::MAG_W-1:0]       mul_p;
	logic [gsc_pkg::DEN_W+1:0]         sq_trial;
	logic [gsc_pkg::DEN_W+1:0]         sq_cand;
	logic                              sq_ge;
	logic [gsc_pkg::DEN_W+1:0]         sq_diff;
	logic [gsc_pkg::DZ_W-1:0]          m;
	logic                              in_zone;
	logic [gsc_pkg::DZ_W-1:0]          dspan;
	logic [gsc_pkg::DZ_W-1:0]          excess;
	logic                              div_start;
	logic [gsc_pkg::DIV_W-1:0]         div_num;
	logic [gsc_pkg::DEN_W-1:0]         div_den;
	logic                              div_done;
	logic [gsc_pkg::DIV_W-1:0]         div_quo;
	logic [gsc_pkg::OUT_W-1:0]         q_mag;

	// Shared multiplier: squares first, then axis times rescaled magnitude.
	always_comb begin
		case (state_q)
			L_SQX: begin
				mul_a = ax_q;
				mul_b = ax_q;
			end
			L_SQY: begin
				mul_a = ay_q;
				mul_b = ay_q;
			end
			L_XMUL: begin
				mul_a = ax_q;
				mul_b = n_q;
			end
			default: begin
				mul_a = ay_q;
				mul_b = n_q;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Square root step: two radicand bits in, one root bit out.
	always_comb begin
		sq_trial = {srem_q, rad_q[gsc_pkg::DIV_W-1 -: 2]};
		sq_cand = {2'b00, root_q, 2'b01};
		sq_ge = sq_trial >= sq_cand;
		sq_diff = sq_trial - sq_cand;
	end

	// Clamp the magnitude and test it against the deadzone.
	always_comb begin
		m = (root_q > gsc_pkg::ROOT_W'(gsc_pkg::STICK_FULL)) ? gsc_pkg::STICK_FULL
			: root_q[gsc_pkg::DZ_W-1:0];
		in_zone = m <= dz_q;
		dspan = gsc_pkg::STICK_FULL - dz_q;
		excess = m - dz_q;
	end

	// Divider operands for the magnitude rescale and the two axis shares.
	always_comb begin
		div_start = (state_q == L_NLD && !in_zone) || state_q == L_XLD || state_q == L_YLD;
		if (state_q == L_NLD) begin
			div_num = {1'b0, excess, 16'd0} + {17'd0, dspan};
			div_den = {2'b00, dspan, 1'b0};
		end else begin
			div_num = {prod_q[gsc_pkg::DIV_W-2:0], 1'b0} + {16'd0, root_q};
			div_den = {1'b0, root_q, 1'b0};
		end
		q_mag = div_quo[gsc_pkg::OUT_W-1:0];
	end

	gsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			case (state_q)
				L_SQX:  state_q <= L_SQY;
				L_SQY:  state_q <= L_ROOT;
				L_ROOT: if (rcnt_q == gsc_pkg::ROOT_CNT_W'(gsc_pkg::ROOT_W - 1)) state_q <= L_NLD;
				L_NLD:  state_q <= in_zone ? L_DONE : L_NDIV;
				L_NDIV: if (div_done) state_q <= L_XMUL;
				L_XMUL: state_q <= L_XLD;
				L_XLD:  state_q <= L_XDIV;
				L_XDIV: if (div_done) state_q <= L_YMUL;
				L_YMUL: state_q <= L_YLD;
				L_YLD:  state_q <= L_YDIV;
				L_YDIV: if (div_done) state_q <= L_DONE;
				default: ;
			endcase
			if (start) begin
				state_q <= L_SQX;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			ax_q <= x[gsc_pkg::AXIS_W-1] ? (17'd0 - {x[gsc_pkg::AXIS_W-1], x}) : {1'b0, x};
			ay_q <= y[gsc_pkg::AXIS_W-1] ? (17'd0 - {y[gsc_pkg::AXIS_W-1], y}) : {1'b0, y};
			sx_q <= x[gsc_pkg::AXIS_W-1];
			sy_q <= y[gsc_pkg::AXIS_W-1];
			dz_q <= deadzone;
		end
		case (state_q)
			L_SQX: sum_q <= mul_p[gsc_pkg::DIV_W-1:0];
			L_SQY: begin
				rad_q <= sum_q + mul_p[gsc_pkg::DIV_W-1:0];
				root_q <= '0;
				srem_q <= '0;
				rcnt_q <= '0;
			end
			L_ROOT: begin
				rad_q <= {rad_q[gsc_pkg::DIV_W-3:0], 2'b00};
				root_q <= {root_q[gsc_pkg::ROOT_W-2:0], sq_ge};
				srem_q <= sq_ge ? sq_diff[gsc_pkg::DEN_W-1:0] : sq_trial[gsc_pkg::DEN_W-1:0];
				rcnt_q <= rcnt_q + 1'b1;
			end
			L_NLD: if (in_zone) begin
				ox_q <= '0;
				oy_q <= '0;
			end
			L_NDIV: if (div_done) n_q <= div_quo[gsc_pkg::MAG_W-1:0];
			L_XMUL, L_YMUL: prod_q <= mul_p[gsc_pkg::DIV_W-1:0];
			L_XDIV: if (div_done) ox_q <= sx_q ? $signed(17'd0 - q_mag) : $signed(q_mag);
			L_YDIV: if (div_done) oy_q <= sy_q ? $signed(17'd0 - q_mag) : $signed(q_mag);
			default: ;
		endcase
	end

	assign done = state_q == L_DONE;
	assign out_x = ox_q;
	assign out_y = oy_q;

endmodule
`default_nettype wire

// ===== src/gamepad_sample_conditioner.sv =====
// Top level of the gamepad sample conditioner: register port, button logic,
// trigger scaling and the two stick lanes. Depends on gsc_pkg, gsc_stick and gsc_div.
//
// Usage: one input item is one controller poll, and one result item follows for each.
// Both channels use valid/ready. An item is taken when in_valid and in_ready are
// high. in_ready is high while the engine is free, even while the previous result
// still waits in the output register. The button flags are worked out when the
// item is taken. The two stick lanes then run in parallel with the trigger path.
// Each lane squares both axes in turn on one multiplier and then takes a bit-serial
// square root. Outside the deadzone it then runs three serial divisions, each one
// prepared in a load state (for the axis shares after a multiply state). When a
// stick leaves its deadzone, the lanes set when the result appears, because the two
// trigger divisions share one divider and are done sooner. With both sticks inside
// their deadzones and both triggers at or below the threshold, no division runs and
// the result appears soonest. One item is in work at a time, so a new item is taken
// only after the previous one has finished. When out_ready stays low the finished
// result waits in the engine until the output register frees, and no item is taken
// meanwhile. Reset clears the handshake and the previous button word, sets the
// first-poll flag, and loads the deadzones and the trigger threshold with their
// defaults. Registers are written at byte addresses 0, 4 and 8.
`default_nettype none
module gamepad_sample_conditioner (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [3:0]                             paddr,
	input  wire logic [31:0]                            pwdata,
	output logic [31:0]                                 prdata,
	output logic                                        pready,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic                                   connected,
	input  wire logic [15:0]                            buttons,
	input  wire logic signed [gsc_pkg::AXIS_W-1:0]      left_x,
	input  wire logic signed [gsc_pkg::AXIS_W-1:0]      left_y,
	input  wire logic signed [gsc_pkg::AXIS_W-1:0]      right_x,
	input  wire logic signed [gsc_pkg::AXIS_W-1:0]      right_y,
	input  wire logic [gsc_pkg::TRIG_W-1:0]             left_trigger,
	input  wire logic [gsc_pkg::TRIG_W-1:0]             right_trigger,
	input  wire logic [15:0]                            query_mask,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic                                        held,
	output logic                                        pressed_edge,
	output logic                                        released_edge,
	output logic                                        mask_error,
	output logic signed [gsc_pkg::OUT_W-1:0]            left_out_x,
	output logic signed [gsc_pkg::OUT_W-1:0]            left_out_y,
	output logic signed [gsc_pkg::OUT_W-1:0]            right_out_x,
	output logic signed [gsc_pkg::OUT_W-1:0]            right_out_y,
	output logic [gsc_pkg::TRIG_OUT_W-1:0]              left_trigger_out,
	output logic [gsc_pkg::TRIG_OUT_W-1:0]              right_trigger_out
);

	typedef enum logic [1:0] {
		REG_LEFT_DZ  = 2'd0,
		REG_RIGHT_DZ = 2'd1,
		REG_TRIG_THR = 2'd2
	} reg_index_t;

	typedef enum logic [5:0] {
		T_IDLE = 6'b000001,
		T_LLD  = 6'b000010,
		T_LDIV = 6'b000100,
		T_RLD  = 6'b001000,
		T_RDIV = 6'b010000,
		T_WAIT = 6'b100000
	} top_state_t;

	top_state_t                        state_q;
	logic [gsc_pkg::DZ_W-1:0]          left_dz_q;
	logic [gsc_pkg::DZ_W-1:0]          right_dz_q;
	logic [gsc_pkg::TRIG_W-1:0]        thr_q;
	logic [15:0]                       last_buttons_q;
	logic                              first_poll_q;
	logic                              held_q;
	logic                              pressed_q;
	logic                              released_q;
	logic                              merr_q;
	logic [gsc_pkg::TRIG_W-1:0]        lt_q;
	logic [gsc_pkg::TRIG_W-1:0]        rt_q;
	logic [gsc_pkg::TRIG_OUT_W-1:0]    lt_res_q;
	logic [gsc_pkg::TRIG_OUT_W-1:0]    rt_res_q;
	logic                              out_valid_q;
	logic                              o_held_q;
	logic                              o_pressed_q;
	logic                              o_released_q;
	logic                              o_merr_q;
	logic signed [gsc_pkg::OUT_W-1:0]  o_lx_q;
	logic signed [gsc_pkg::OUT_W-1:0]  o_ly_q;
	logic signed [gsc_pkg::OUT_W-1:0]  o_rx_q;
	logic signed [gsc_pkg::OUT_W-1:0]  o_ry_q;
	logic [gsc_pkg::TRIG_OUT_W-1:0]    o_lt_q;
	logic [gsc_pkg::TRIG_OUT_W-1:0]    o_rt_q;

	logic                              in_take;
	logic                              cfg_write;
	reg_index_t                        cfg_idx;
	logic [15:0]                       cur;
	logic [15:0]                       prev;
	logic                              now_all;
	logic                              prev_all;
	logic                              merr;
	logic signed [gsc_pkg::AXIS_W-1:0] lx_eff;
	logic signed [gsc_pkg::AXIS_W-1:0] ly_eff;
	logic signed [gsc_pkg::AXIS_W-1:0] rx_eff;
	logic signed [gsc_pkg::AXIS_W-1:0] ry_eff;
	gsc_pkg::lane_ctl_t                left_ctl;
	gsc_pkg::lane_ctl_t                right_ctl;
	logic signed [gsc_pkg::OUT_W-1:0]  lane_lx;
	logic signed [gsc_pkg::OUT_W-1:0]  lane_ly;
	logic signed [gsc_pkg::OUT_W-1:0]  lane_rx;
	logic signed [gsc_pkg::OUT_W-1:0]  lane_ry;
	logic [gsc_pkg::TRIG_W-1:0]        trig_v;
	logic                              trig_zero;
	logic [gsc_pkg::TRIG_W-1:0]        trig_span;
	logic [gsc_pkg::TRIG_W-1:0]        trig_excess;
	logic                              tdiv_start;
	logic [gsc_pkg::DIV_W-1:0]         tdiv_num;
	logic [gsc_pkg::DEN_W-1:0]         tdiv_den;
	logic                              tdiv_done;
	logic [gsc_pkg::DIV_W-1:0]         tdiv_quo;
	logic                              finish;

	assign in_take = in_valid && in_ready;
	assign in_ready = state_q == T_IDLE;
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_idx = reg_index_t'(paddr[3:2]);

	// Register file writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dz_q <= 15'd7849;
			right_dz_q <= 15'd8689;
			thr_q <= 8'd30;
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_LEFT_DZ:  left_dz_q <= pwdata[gsc_pkg::DZ_W-1:0];
				REG_RIGHT_DZ: right_dz_q <= pwdata[gsc_pkg::DZ_W-1:0];
				REG_TRIG_THR: thr_q <= pwdata[gsc_pkg::TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	// Register file reads.
	always_comb begin
		case (cfg_idx)
			REG_LEFT_DZ:  prdata = {17'd0, left_dz_q};
			REG_RIGHT_DZ: prdata = {17'd0, right_dz_q};
			REG_TRIG_THR: prdata = {24'd0, thr_q};
			default:      prdata = '0;
		endcase
	end

	// Effective poll and button combination flags.
	always_comb begin
		cur = connected ? buttons : 16'd0;
		prev = first_poll_q ? cur : last_buttons_q;
		merr = query_mask == 16'd0;
		now_all = (cur & query_mask) == query_mask;
		prev_all = (prev & query_mask) == query_mask;
		lx_eff = connected ? left_x : '0;
		ly_eff = connected ? left_y : '0;
		rx_eff = connected ? right_x : '0;
		ry_eff = connected ? right_y : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_buttons_q <= '0;
			first_poll_q <= 1'b1;
		end else if (in_take) begin
			last_buttons_q <= cur;
			first_poll_q <= 1'b0;
		end
	end

	// Stick lanes start on the accepted item.
	assign left_ctl.start = in_take;
	assign right_ctl.start = in_take;

	gsc_stick u_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (left_ctl.start),
		.x        (lx_eff),
		.y        (ly_eff),
		.deadzone (left_dz_q),
		.done     (left_ctl.done),
		.out_x    (lane_lx),
		.out_y    (lane_ly)
	);

	gsc_stick u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (right_ctl.start),
		.x        (rx_eff),
		.y        (ry_eff),
		.deadzone (right_dz_q),
		.done     (right_ctl.done),
		.out_x    (lane_rx),
		.out_y    (lane_ry)
	);

	// Trigger scaling on one shared divider, left then right.
	always_comb begin
		trig_v = (state_q == T_LLD) ? lt_q : rt_q;
		trig_zero = trig_v <= thr_q;
		trig_span = gsc_pkg::TRIG_FULL - thr_q;
		trig_excess = trig_v - thr_q;
		tdiv_start = (state_q == T_LLD || state_q == T_RLD) && !trig_zero;
		tdiv_num = {8'd0, trig_excess, 16'd0} + {24'd0, trig_span};
		tdiv_den = {9'd0, trig_span, 1'b0};
	end

	gsc_div u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (tdiv_start),
		.dividend (tdiv_num),
		.divisor  (tdiv_den),
		.done     (tdiv_done),
		.quotient (tdiv_quo)
	);

	assign finish = state_q == T_WAIT && left_ctl.done && right_ctl.done
		&& (!out_valid_q || out_ready);

	// Engine sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			case (state_q)
				T_IDLE: if (in_take) state_q <= T_LLD;
				T_LLD:  state_q <= trig_zero ? T_RLD : T_LDIV;
				T_LDIV: if (tdiv_done) state_q <= T_RLD;
				T_RLD:  state_q <= trig_zero ? T_WAIT : T_RDIV;
				T_RDIV: if (tdiv_done) state_q <= T_WAIT;
				T_WAIT: if (finish) state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// Per-item working registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			held_q <= !merr && connected && now_all;
			pressed_q <= !merr && connected && now_all && !prev_all;
			released_q <= !merr && !now_all && prev_all;
			merr_q <= merr;
			lt_q <= connected ? left_trigger : '0;
			rt_q <= connected ? right_trigger : '0;
		end
		if (state_q == T_LLD && trig_zero) lt_res_q <= '0;
		if (state_q == T_LDIV && tdiv_done) lt_res_q <= tdiv_quo[gsc_pkg::TRIG_OUT_W-1:0];
		if (state_q == T_RLD && trig_zero) rt_res_q <= '0;
		if (state_q == T_RDIV && tdiv_done) rt_res_q <= tdiv_quo[gsc_pkg::TRIG_OUT_W-1:0];
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			o_held_q <= held_q;
			o_pressed_q <= pressed_q;
			o_released_q <= released_q;
			o_merr_q <= merr_q;
			o_lx_q <= lane_lx;
			o_ly_q <= lane_ly;
			o_rx_q <= lane_rx;
			o_ry_q <= lane_ry;
			o_lt_q <= lt_res_q;
			o_rt_q <= rt_res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign held = o_held_q;
	assign pressed_edge = o_pressed_q;
	assign released_edge = o_released_q;
	assign mask_error = o_merr_q;
	assign left_out_x = o_lx_q;
	assign left_out_y = o_ly_q;
	assign right_out_x = o_rx_q;
	assign right_out_y = o_ry_q;
	assign left_trigger_out = o_lt_q;
	assign right_trigger_out = o_rt_q;

	// A new edge implies the combination is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pressed_edge |-> held)
		else $error("pressed edge without held");

	// A zero mask suppresses every button flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mask_error |-> !held && !pressed_edge && !released_edge)
		else $error("button flags set with zero mask");

	// Only one item is in work at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("engine took a second item");

	// Trigger scaling never exceeds full scale.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_trigger_out <= 16'd32768 && right_trigger_out <= 16'd32768)
		else $error("trigger output above full scale");

endmodule
`default_nettype wire
